>>> rtl/arq_pkg.sv
package arq_pkg;

  localparam int DEF_WINDOW_SLOTS = 8;
  localparam int DEF_PACKET_BYTES = 1024;
  localparam int TIMEOUT_LIMIT    = 15;
  localparam int LEN_W            = 24;
  localparam int CMD_W            = 2;

  localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [LEN_W-1:0] ack_offset;
  } in_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] packet_offset;
    logic             odd_relay;
    logic             final_packet;
    logic             is_resend;
    logic             transfer_done;
    logic             run_end;
  } out_item_t;

  // one unit of work handed from the command front to the send sequencer
  typedef struct packed {
    logic             done;
    logic             resend;
    logic             parity;
    logic [LEN_W-1:0] win_start;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FLUSH
  } back_state_t;

endpackage

>>> rtl/arq_queue.sv
module arq_queue import arq_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/arq_front.sv
module arq_front import arq_pkg::*; #(
  parameter int WINDOW_SLOTS = DEF_WINDOW_SLOTS,
  parameter int PACKET_BYTES = DEF_PACKET_BYTES
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  in_item_t                item,
  input  logic [LEN_W-1:0]        total_length,
  output logic                    job_push,
  output job_t                    job,
  output logic [WINDOW_SLOTS-1:0] job_skip
);

  localparam logic [LEN_W:0] WIN_BYTES = (LEN_W + 1)'(WINDOW_SLOTS * PACKET_BYTES);
  localparam logic           WIN_ODD   = 1'(WINDOW_SLOTS % 2);

  logic [LEN_W-1:0]        win_start, win_start_next;
  logic [WINDOW_SLOTS-1:0] marks, marks_next;
  logic [3:0]              tcount, tcount_next;
  logic                    active, active_next;
  logic                    wpar, wpar_next;

  logic                    ws_below;
  logic [LEN_W-1:0]        remain;
  logic [LEN_W-1:0]        ack_rel;
  logic                    ack_ge;
  logic [WINDOW_SLOTS-1:0] in_range;
  logic [WINDOW_SLOTS-1:0] hit;
  logic [WINDOW_SLOTS-1:0] marks_hit;
  logic [LEN_W:0]          next_start;
  logic [3:0]              tinc;

  assign ws_below   = win_start < total_length;
  assign remain     = total_length - win_start;
  assign ack_ge     = item.ack_offset >= win_start;
  assign ack_rel    = item.ack_offset - win_start;
  assign marks_hit  = marks | hit;
  assign next_start = {1'b0, win_start} + WIN_BYTES;
  assign tinc       = tcount + 4'd1;

  // slot i is in range when its offset lies below the total length
  always_comb begin
    for (int i = 0; i < WINDOW_SLOTS; i++) begin
      in_range[i] = ws_below && (remain > LEN_W'(i * PACKET_BYTES));
      hit[i]      = ack_ge && (ack_rel >= LEN_W'(i * PACKET_BYTES)) &&
                    (ack_rel < LEN_W'((i + 1) * PACKET_BYTES));
    end
  end

  always_comb begin
    win_start_next = win_start;
    marks_next     = marks;
    tcount_next    = tcount;
    active_next    = active;
    wpar_next      = wpar;
    job_push       = 1'b0;
    job            = '{done: 1'b0, resend: 1'b0, parity: wpar, win_start: win_start};
    job_skip       = '0;
    if (accept) begin
      unique case (item.cmd)
        CMD_START: begin
          win_start_next = '0;
          marks_next     = '0;
          tcount_next    = '0;
          wpar_next      = 1'b0;
          job_push       = 1'b1;
          job.parity     = 1'b0;
          job.win_start  = '0;
          if (total_length == '0) begin
            active_next = 1'b0;
            job.done    = 1'b1;
          end else begin
            active_next = 1'b1;
          end
        end
        CMD_ACK: begin
          if (active) begin
            tcount_next = '0;
            if (|hit) begin
              if (&(~in_range | marks_hit)) begin
                // window fully acknowledged: advance
                marks_next     = '0;
                win_start_next = next_start[LEN_W-1:0];
                job_push       = 1'b1;
                if (next_start >= {1'b0, total_length}) begin
                  active_next = 1'b0;
                  job.done    = 1'b1;
                end else begin
                  wpar_next     = wpar ^ WIN_ODD;
                  job.parity    = wpar ^ WIN_ODD;
                  job.win_start = next_start[LEN_W-1:0];
                end
              end else begin
                marks_next = marks_hit;
              end
            end
          end
        end
        CMD_TIMEOUT: begin
          if (active) begin
            job_push   = 1'b1;
            job.resend = 1'b1;
            if (!ws_below) begin
              tcount_next = tinc;
              active_next = 1'b0;
              job.done    = 1'b1;
            end else if (tinc == 4'(TIMEOUT_LIMIT) || !(|(in_range & ~marks))) begin
              tcount_next = '0;
            end else begin
              tcount_next = tinc;
              job_skip    = marks;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_start <= '0;
      marks     <= '0;
      tcount    <= '0;
      active    <= 1'b0;
      wpar      <= 1'b0;
    end else begin
      win_start <= win_start_next;
      marks     <= marks_next;
      tcount    <= tcount_next;
      active    <= active_next;
      wpar      <= wpar_next;
    end
  end

`ifndef SYNTHESIS
  a_tcount_wraps: assert property (@(posedge clk) disable iff (rst)
    tcount == 4'(TIMEOUT_LIMIT) |-> !active)
    else $error("timeout count at the limit during a transfer");

  a_done_ends_transfer: assert property (@(posedge clk) disable iff (rst)
    job_push && job.done |=> !active)
    else $error("transfer still active after done status");
`endif

endmodule

>>> rtl/arq_back.sv
module arq_back import arq_pkg::*; #(
  parameter int WINDOW_SLOTS = DEF_WINDOW_SLOTS,
  parameter int PACKET_BYTES = DEF_PACKET_BYTES
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    job_valid,
  input  job_t                    job,
  input  logic [WINDOW_SLOTS-1:0] job_skip,
  output logic                    job_pop,
  input  logic [LEN_W-1:0]        total_length,
  output logic                    out_push,
  output out_item_t               out_item,
  input  logic                    out_full
);

  localparam int             IDX_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam logic [LEN_W:0]   PB25  = (LEN_W + 1)'(PACKET_BYTES);
  localparam logic [LEN_W+1:0] PB26  = (LEN_W + 2)'(PACKET_BYTES);

  back_state_t             st, st_next;
  logic [LEN_W:0]          off, off_next;
  logic [IDX_W-1:0]        idx, idx_next;
  logic                    par, par_next;
  logic                    rs, rs_next;
  logic [WINDOW_SLOTS-1:0] skip, skip_next;
  logic                    pend_v, pend_v_next;
  out_item_t               pend, pend_next;

  logic                    in_rng;
  logic                    cand;
  logic                    stop;
  out_item_t               cur;

  assign in_rng = off < {1'b0, total_length};
  assign cand   = in_rng && !skip[idx];
  assign stop   = !in_rng || (idx == IDX_W'(WINDOW_SLOTS - 1));

  always_comb begin
    cur.packet_offset = off[LEN_W-1:0];
    cur.odd_relay     = par;
    cur.final_packet  = ({1'b0, off} + PB26) >= {2'b00, total_length};
    cur.is_resend     = rs;
    cur.transfer_done = 1'b0;
    cur.run_end       = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= BK_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next     = st;
    off_next    = off;
    idx_next    = idx;
    par_next    = par;
    rs_next     = rs;
    skip_next   = skip;
    pend_v_next = pend_v;
    pend_next   = pend;
    job_pop     = 1'b0;
    out_push    = 1'b0;
    out_item    = pend;
    unique case (st)
      BK_IDLE: begin
        if (job_valid) begin
          if (job.done) begin
            if (!out_full) begin
              out_push               = 1'b1;
              out_item               = '0;
              out_item.transfer_done = 1'b1;
              out_item.run_end       = 1'b1;
              job_pop                = 1'b1;
            end
          end else begin
            off_next  = {1'b0, job.win_start};
            idx_next  = '0;
            par_next  = job.parity;
            rs_next   = job.resend;
            skip_next = job_skip;
            job_pop   = 1'b1;
            st_next   = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        // the latest send is held back until the next one is found, so the last one can carry run_end
        if (!(cand && pend_v && out_full)) begin
          if (cand) begin
            out_push    = pend_v;
            pend_next   = cur;
            pend_v_next = 1'b1;
          end
          off_next = off + PB25;
          idx_next = idx + 1'b1;
          par_next = ~par;
          if (stop) begin
            st_next = BK_FLUSH;
          end
        end
      end
      BK_FLUSH: begin
        if (!out_full) begin
          out_push         = pend_v;
          out_item.run_end = 1'b1;
          pend_v_next      = 1'b0;
          st_next          = BK_IDLE;
        end
      end
      default: begin
        st_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else begin
      pend_v <= pend_v_next;
    end
  end

  always_ff @(posedge clk) begin
    off  <= off_next;
    idx  <= idx_next;
    par  <= par_next;
    rs   <= rs_next;
    skip <= skip_next;
    pend <= pend_next;
  end

`ifndef SYNTHESIS
  a_flush_has_send: assert property (@(posedge clk) disable iff (rst)
    st == BK_FLUSH |-> pend_v)
    else $error("window scan ended without any send");

  a_send_job_starts_scan: assert property (@(posedge clk) disable iff (rst)
    st == BK_IDLE && job_valid && !job.done |=> st == BK_SCAN)
    else $error("send job not taken into scan");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    st == BK_IDLE |-> !pend_v)
    else $error("held send left behind after scan");
`endif

endmodule

>>> rtl/windowed_arq_sender.sv
// Sender side of a window-at-a-time selective-repeat ARQ. Commands (start,
// ack, timeout) enter through a queue-style push/full port and are decoded at
// once by the command front, which keeps the window start, the per-slot ack
// marks and the timeout count, and hands one job per command that produces
// output into a two-entry job queue. The send sequencer walks a window one
// slot per cycle while the output queue has room: a job sending a window is
// loaded, walked slot by slot and ended by a final flush; a done status is
// sent from idle, so the slot walk sets the sustained rate. The front takes a
// command every cycle while the job queue has room, and results wait in a
// two-entry output queue read through empty/pop. total_length is written
// through cfg_valid/cfg_ready, which is always ready, and is read live.
module windowed_arq_sender import arq_pkg::*; #(
  parameter int WINDOW_SLOTS = DEF_WINDOW_SLOTS,
  parameter int PACKET_BYTES = DEF_PACKET_BYTES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  in_item_t         item,
  output logic             full,
  input  logic             pop,
  output out_item_t        result,
  output logic             empty,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data
);

  localparam int JOB_W = $bits(job_t) + WINDOW_SLOTS;
  localparam int OUT_W = $bits(out_item_t);

  logic [LEN_W-1:0]        total_length;
  logic                    accept;
  logic                    fj_push;
  job_t                    fj;
  logic [WINDOW_SLOTS-1:0] fj_skip;
  logic [JOB_W-1:0]        jq_rdata;
  logic                    jq_empty;
  logic                    jq_pop;
  job_t                    bj;
  logic [WINDOW_SLOTS-1:0] bj_skip;
  logic                    oq_push;
  out_item_t               oq_item;
  logic                    oq_full;
  logic [OUT_W-1:0]        oq_rdata;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;
  assign bj        = jq_rdata[JOB_W-1:WINDOW_SLOTS];
  assign bj_skip   = jq_rdata[WINDOW_SLOTS-1:0];
  assign result    = oq_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      total_length <= cfg_data;
    end
  end

  arq_front #(
    .WINDOW_SLOTS(WINDOW_SLOTS),
    .PACKET_BYTES(PACKET_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .item         (item),
    .total_length (total_length),
    .job_push     (fj_push),
    .job          (fj),
    .job_skip     (fj_skip)
  );

  arq_queue #(
    .WIDTH(JOB_W),
    .DEPTH(2)
  ) u_job_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fj_push),
    .wr_data ({fj, fj_skip}),
    .rd_en   (jq_pop),
    .rd_data (jq_rdata),
    .full    (full),
    .empty   (jq_empty)
  );

  arq_back #(
    .WINDOW_SLOTS(WINDOW_SLOTS),
    .PACKET_BYTES(PACKET_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (!jq_empty),
    .job          (bj),
    .job_skip     (bj_skip),
    .job_pop      (jq_pop),
    .total_length (total_length),
    .out_push     (oq_push),
    .out_item     (oq_item),
    .out_full     (oq_full)
  );

  arq_queue #(
    .WIDTH(OUT_W),
    .DEPTH(2)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (oq_push),
    .wr_data (oq_item),
    .rd_en   (pop),
    .rd_data (oq_rdata),
    .full    (oq_full),
    .empty   (empty)
  );

endmodule

>>> sim/windowed_arq_sender_test.sv
module windowed_arq_sender_test import arq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS         = DEF_WINDOW_SLOTS;
  localparam int PKT           = DEF_PACKET_BYTES;
  localparam int IDLE_PCT      = 18;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 32;
  localparam int RANDOM_ITEMS  = 420;
  localparam int LIMIT_CYCLES  = 500000;
  localparam int MAX_REPORTS   = 10;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic             clk;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  in_item_t         item = '0;
  logic             full;
  logic             pop = 1'b0;
  out_item_t        result;
  logic             empty;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data = '0;

  logic calm = 1'b0;
  logic hold_armed = 1'b0;
  int   hold_cnt = 0;
  logic rx_hold;
  int   cycles = 0;
  int   mismatches = 0;

  // sender state as the block should see it
  logic [LEN_W-1:0] len_cfg = '0;
  logic [LEN_W-1:0] win_base = '0;
  bit               slot_acked [SLOTS];
  logic [3:0]       tmo_run = '0;
  bit               xfer_on = 1'b0;

  in_item_t  cmd_backlog [$];
  out_item_t burst [$];
  out_item_t due_results [$];

  // where the generator believes the transfer stands at the end of a phase
  logic [31:0] gen_base = '0;
  bit          gen_live = 1'b0;
  int          planned = 0;

  windowed_arq_sender i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .pop       (pop),
    .result    (result),
    .empty     (empty),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void emit_send(logic [31:0] off, bit resend);
    out_item_t r;
    r = '0;
    r.packet_offset = off[LEN_W-1:0];
    r.odd_relay     = ((off / PKT) % 2) != 0;
    r.final_packet  = (off + PKT) >= len_cfg;
    r.is_resend     = resend;
    burst.push_back(r);
  endfunction

  function automatic void emit_done();
    out_item_t r;
    r = '0;
    r.transfer_done = 1'b1;
    burst.push_back(r);
    xfer_on = 1'b0;
  endfunction

  function automatic bit window_has_gap();
    logic [31:0] off;
    for (int i = 0; i < SLOTS; i++) begin
      off = win_base + i * PKT;
      if (off >= len_cfg) break;
      if (!slot_acked[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void send_window(bit resend, bit only_gaps);
    logic [31:0] off;
    if (win_base >= len_cfg) begin
      emit_done();
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        off = win_base + i * PKT;
        if (off >= len_cfg) break;
        if (!(only_gaps && slot_acked[i])) emit_send(off, resend);
      end
    end
  endfunction

  function automatic void predict_command(in_item_t it);
    logic [31:0] next_base;
    int          idx;
    out_item_t   last;
    burst.delete();
    case (it.cmd)
      CMD_START: begin
        win_base = '0;
        foreach (slot_acked[i]) slot_acked[i] = 1'b0;
        tmo_run = '0;
        xfer_on = 1'b1;
        send_window(1'b0, 1'b0);
      end
      CMD_ACK: begin
        if (xfer_on) begin
          tmo_run = '0;
          if (it.ack_offset >= win_base) begin
            idx = (it.ack_offset - win_base) / PKT;
            if (idx < SLOTS) begin
              slot_acked[idx] = 1'b1;
              if (!window_has_gap()) begin
                next_base = win_base + SLOTS * PKT;
                foreach (slot_acked[i]) slot_acked[i] = 1'b0;
                win_base = next_base[LEN_W-1:0];
                if (next_base >= len_cfg) emit_done();
                else send_window(1'b0, 1'b0);
              end
            end
          end
        end
      end
      CMD_TIMEOUT: begin
        if (xfer_on) begin
          tmo_run = tmo_run + 4'd1;
          if (win_base >= len_cfg) begin
            emit_done();
          end else if (tmo_run == TIMEOUT_LIMIT || !window_has_gap()) begin
            // nothing left to fill in, or too many timeouts: whole window again
            tmo_run = '0;
            send_window(1'b1, 1'b0);
          end else begin
            send_window(1'b1, 1'b1);
          end
        end
      end
      default: ;
    endcase
    if (burst.size() != 0) begin
      last = burst.pop_back();
      last.run_end = 1'b1;
      burst.push_back(last);
    end
    foreach (burst[k]) due_results.push_back(burst[k]);
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected result: offset=%0d odd=%0b final=%0b resend=%0b done=%0b end=%0b",
                 got.packet_offset, got.odd_relay, got.final_packet, got.is_resend,
                 got.transfer_done, got.run_end);
    end else begin
      want = due_results.pop_front();
      if (got.packet_offset !== want.packet_offset || got.odd_relay !== want.odd_relay ||
          got.final_packet !== want.final_packet || got.is_resend !== want.is_resend ||
          got.transfer_done !== want.transfer_done || got.run_end !== want.run_end) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch: expected offset=%0d odd=%0b final=%0b resend=%0b done=%0b end=%0b",
                   want.packet_offset, want.odd_relay, want.final_packet, want.is_resend,
                   want.transfer_done, want.run_end);
          $display("          actual   offset=%0d odd=%0b final=%0b resend=%0b done=%0b end=%0b",
                   got.packet_offset, got.odd_relay, got.final_packet, got.is_resend,
                   got.transfer_done, got.run_end);
        end
      end
    end
  endfunction

  // driver: offers the oldest pending command, holds it while full
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) predict_command(cmd_backlog.pop_front());
      if (push && full) begin
        // keep offering the same command
      end else if (cmd_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        push <= 1'b1;
        item <= cmd_backlog[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor: takes a result on each transaction and checks it
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result(result);
      pop <= !rx_hold && (calm || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // long receiver stall, counted once armed
  always @(posedge clk) begin
    if (!rst && hold_armed && hold_cnt < HOLD_CYCLES) hold_cnt <= hold_cnt + 1;
  end
  assign rx_hold = hold_armed && (hold_cnt < HOLD_CYCLES);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("windowed_arq_sender test failed");
      $finish;
    end
  end

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [LEN_W-1:0] off);
    in_item_t it;
    it.cmd = cmd;
    it.ack_offset = off;
    cmd_backlog.push_back(it);
  endtask

  task automatic drain();
    while (cmd_backlog.size() != 0 || due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    len_cfg = value;
  endtask

  // start, then acks for every in-range slot in shuffled order, with timeouts and noise
  task automatic plan_transfer(input logic [LEN_W-1:0] len, input int budget);
    int          order [SLOTS];
    int          in_range, pick, tmp, n, k, roll, reps;
    logic [31:0] base;
    bit          restart;
    n = 0;
    base = '0;
    queue_cmd(CMD_START, LEN_W'($urandom()));
    n++;
    while (n < budget && base < len) begin
      in_range = 0;
      for (k = 0; k < SLOTS; k++) if (base + k * PKT < len) in_range++;
      for (k = 0; k < SLOTS; k++) order[k] = k;
      for (k = in_range - 1; k > 0; k--) begin
        pick = $urandom_range(0, k);
        tmp = order[k];
        order[k] = order[pick];
        order[pick] = tmp;
      end
      restart = 1'b0;
      for (k = 0; k < in_range && !restart; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 14) begin
          queue_cmd(CMD_TIMEOUT, LEN_W'($urandom()));
          n++;
        end else if (roll < 17) begin
          // run of timeouts around the limit
          reps = $urandom_range(TIMEOUT_LIMIT - 1, TIMEOUT_LIMIT + 1);
          repeat (reps) queue_cmd(CMD_TIMEOUT, LEN_W'($urandom()));
          n += reps;
        end else if (roll < 20) begin
          queue_cmd($urandom_range(0, 1) ? CMD_UNUSED : CMD_ACK, LEN_W'($urandom()));
        end else if (roll < 23) begin
          if (in_range < SLOTS)
            queue_cmd(CMD_ACK, LEN_W'(base + $urandom_range(in_range, SLOTS - 1) * PKT));
          else if (base != 0) queue_cmd(CMD_ACK, LEN_W'(base - $urandom_range(1, base)));
        end else if (roll < 26 && k > 0) begin
          queue_cmd(CMD_ACK, LEN_W'(base + order[k - 1] * PKT + $urandom_range(0, PKT - 1)));
        end
        if (roll == 99) begin
          queue_cmd(CMD_START, LEN_W'($urandom()));
          n++;
          restart = 1'b1;
        end else begin
          queue_cmd(CMD_ACK, LEN_W'(base + order[k] * PKT + $urandom_range(0, PKT - 1)));
          n++;
        end
      end
      if (restart) base = '0;
      else if (k == in_range) base = base + SLOTS * PKT;
    end
    gen_base = base;
    gen_live = base < len;
    planned += n;
    if ($urandom_range(0, 3) == 0) queue_cmd(CMD_W'($urandom_range(1, 3)), LEN_W'($urandom()));
  endtask

  initial begin
    logic [LEN_W-1:0] edge_lengths [10];
    logic [LEN_W-1:0] len;
    int               phase;
    edge_lengths = '{24'd1, 24'd1023, 24'd1024, 24'd1025, 24'd8191,
                     24'd8192, 24'd8193, 24'd16384, 24'hFFFFFF, 24'd0};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    drain();

    // empty transfer, idle commands, unknown command
    write_length('0);
    queue_cmd(CMD_ACK, '0);
    queue_cmd(CMD_TIMEOUT, '0);
    queue_cmd(CMD_UNUSED, 24'hFFFFFF);
    queue_cmd(CMD_START, '0);
    drain();

    // largest length: full window, ack far beyond the window
    write_length(24'hFFFFFF);
    queue_cmd(CMD_START, 24'hFFFFFF);
    queue_cmd(CMD_ACK, 24'hFFFFFF);
    queue_cmd(CMD_TIMEOUT, '0);
    drain();

    // partial window, ack past the length, selective resend, completion
    write_length(24'd2500);
    queue_cmd(CMD_START, '0);
    queue_cmd(CMD_ACK, 24'd1500);
    queue_cmd(CMD_ACK, 24'd5000);
    queue_cmd(CMD_TIMEOUT, '0);
    queue_cmd(CMD_ACK, 24'd0);
    queue_cmd(CMD_ACK, 24'd2100);
    drain();

    // shrinking the length under marked slots leaves nothing to fill in
    write_length(24'd3000);
    queue_cmd(CMD_START, '0);
    queue_cmd(CMD_ACK, 24'd0);
    queue_cmd(CMD_ACK, 24'd1024);
    drain();
    write_length(24'd2000);
    queue_cmd(CMD_TIMEOUT, '0);
    queue_cmd(CMD_START, '0);
    gen_base = '0;
    gen_live = 1'b1;

    phase = 0;
    while (planned < RANDOM_ITEMS) begin
      drain();
      calm <= (phase == 2);
      if (phase == 4) hold_armed <= 1'b1;
      if (gen_live && gen_base != 0 && $urandom_range(0, 1)) begin
        // length cut below the current window while the transfer is live
        write_length(LEN_W'($urandom_range(1, gen_base)));
        queue_cmd(CMD_TIMEOUT, LEN_W'($urandom()));
        queue_cmd(CMD_ACK, LEN_W'($urandom()));
        drain();
      end
      case ($urandom_range(0, 7))
        0: len = edge_lengths[$urandom_range(0, 9)];
        1: len = LEN_W'($urandom());
        default: len = LEN_W'($urandom_range(1, 40000));
      endcase
      write_length(len);
      plan_transfer(len, (phase == 4) ? 60 : $urandom_range(12, 50));
      phase++;
    end

    drain();
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("windowed_arq_sender test passed");
    end else begin
      $display("windowed_arq_sender test failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/arq_pkg.sv
rtl/arq_queue.sv
rtl/arq_front.sv
rtl/arq_back.sv
rtl/windowed_arq_sender.sv
sim/windowed_arq_sender_test.sv
